// File: rtl/one_wire_master_uart_slots_unit_defines.svh
// Assertion macros shared by the one-wire master RTL.
`ifndef ONE_WIRE_MASTER_UART_SLOTS_UNIT_DEFINES_SVH
`define ONE_WIRE_MASTER_UART_SLOTS_UNIT_DEFINES_SVH

`ifndef SYNTH
`define OWMU_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define OWMU_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);
`else
`define OWMU_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define OWMU_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`endif

`endif

// File: rtl/owmu_pkg.sv
// Types, constants and the CRC-8 function of the one-wire master.
package owmu_pkg;

    localparam logic [1:0] FUNC_RESET = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;
    localparam logic [1:0] FUNC_ECHO  = 2'd3;

    localparam logic [7:0] RESET_PATTERN = 8'hF0;
    localparam logic [7:0] SLOT_ONE      = 8'hFF;
    localparam logic [7:0] SLOT_ZERO     = 8'h00;
    localparam logic [7:0] CRC_POLY      = 8'h8C;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data;
    } in_item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] tx_byte;
        logic       slow_baud;
        logic [7:0] read_byte;
        logic       presence;
        logic [7:0] crc_value;
        logic       busy_error;
        logic       last;
    } out_item_t;

    typedef enum logic {
        JOB_SINGLE = 1'b0,
        JOB_WRITE  = 1'b1
    } job_op_t;

    typedef struct packed {
        job_op_t    op;
        out_item_t  res;
        logic [7:0] wdata;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [7:0] crc8_update(input logic [7:0] acc_in,
                                               input logic [7:0] byte_in);
        logic [7:0] acc;
        logic [7:0] b;
        logic       mix;
        acc = acc_in;
        b   = byte_in;
        for (int k = 0; k < 8; k++)
        begin
            mix = acc[0] ^ b[0];
            acc = acc >> 1;
            if (mix)
            begin
                acc = acc ^ CRC_POLY;
            end
            b = b >> 1;
        end
        return acc;
    endfunction

endpackage

// File: rtl/owmu_front.sv
// Command front end: bus state, read assembly, CRC and job classification.
module owmu_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    output logic                   cmd_stall,
    input  owmu_pkg::in_item_t     cmd,
    input  owmu_pkg::queue_status_t q_status,
    output logic                   push,
    output owmu_pkg::job_t         push_job
);
    import owmu_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'b001,
        MODE_RESET = 3'b010,
        MODE_READ  = 3'b100
    } mode_t;

    mode_t      mode_reg, mode_next;
    logic [3:0] bit_count_reg, bit_count_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] crc_reg, crc_next;
    logic       accept;
    logic       busy;
    logic [7:0] shift_in;
    logic [3:0] count_in;

    assign cmd_stall = q_status.full;
    assign accept    = cmd_valid && !q_status.full;
    assign busy      = (mode_reg == MODE_RESET) || (mode_reg == MODE_READ);
    assign shift_in  = {cmd.data[0], shift_reg[7:1]};
    assign count_in  = bit_count_reg + 4'd1;

    always_comb
    begin
        mode_next      = mode_reg;
        bit_count_next = bit_count_reg;
        shift_next     = shift_reg;
        crc_next       = crc_reg;
        push           = 1'b0;
        push_job       = '0;
        push_job.op    = JOB_SINGLE;
        push_job.res.crc_value = crc_reg;
        push_job.res.last      = 1'b1;
        if (accept)
        begin
            if (cmd.func == FUNC_ECHO)
            begin
                case (mode_reg)
                    MODE_RESET:
                    begin
                        mode_next             = MODE_IDLE;
                        push                  = 1'b1;
                        push_job.res.kind     = 1'b1;
                        push_job.res.presence = (cmd.data != RESET_PATTERN);
                    end
                    MODE_READ:
                    begin
                        push           = 1'b1;
                        shift_next     = shift_in;
                        bit_count_next = count_in;
                        if (count_in < BITS_PER_BYTE)
                        begin
                            push_job.res.tx_byte = SLOT_ONE;
                        end
                        else
                        begin
                            crc_next               = crc8_update(crc_reg, shift_in);
                            mode_next              = MODE_IDLE;
                            push_job.res.kind      = 1'b1;
                            push_job.res.read_byte = shift_in;
                            push_job.res.crc_value = crc_next;
                        end
                    end
                    default:
                    begin
                        push = 1'b0;
                    end
                endcase
            end
            else if (busy)
            begin
                push                    = 1'b1;
                push_job.res.kind       = 1'b1;
                push_job.res.busy_error = 1'b1;
            end
            else
            begin
                push = 1'b1;
                case (cmd.func)
                    FUNC_RESET:
                    begin
                        crc_next               = '0;
                        mode_next              = MODE_RESET;
                        push_job.res.tx_byte   = RESET_PATTERN;
                        push_job.res.slow_baud = 1'b1;
                        push_job.res.crc_value = '0;
                    end
                    FUNC_WRITE:
                    begin
                        push_job.op    = JOB_WRITE;
                        push_job.wdata = cmd.data;
                    end
                    default:
                    begin
                        mode_next            = MODE_READ;
                        bit_count_next       = '0;
                        shift_next           = '0;
                        push_job.res.tx_byte = SLOT_ONE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            bit_count_reg <= '0;
            shift_reg     <= '0;
            crc_reg       <= '0;
        end
        else
        begin
            mode_reg      <= mode_next;
            bit_count_reg <= bit_count_next;
            shift_reg     <= shift_next;
            crc_reg       <= crc_next;
        end
    end

endmodule

// File: rtl/owmu_fifo.sv
// Short job queue between the front end and the slot sequencer.
`include "one_wire_master_uart_slots_unit_defines.svh"

module owmu_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  owmu_pkg::job_t          push_job,
    input  logic                    pop,
    output owmu_pkg::job_t          head,
    output owmu_pkg::queue_status_t status
);
    import owmu_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `OWMU_ASSERT_IMPLIES(a_no_overflow, clk, rst_n, push, !status.full, "push into full queue")
    `OWMU_ASSERT_IMPLIES(a_no_underflow, clk, rst_n, pop, !status.empty, "pop from empty queue")

endmodule

// File: rtl/owmu_back.sv
// Slot sequencer: expands queued jobs into result transactions.
`include "one_wire_master_uart_slots_unit_defines.svh"

module owmu_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  owmu_pkg::queue_status_t q_status,
    input  owmu_pkg::job_t          head,
    output logic                    pop,
    output logic                    res_valid,
    input  logic                    res_stall,
    output owmu_pkg::out_item_t     res
);
    import owmu_pkg::*;

    logic       res_valid_reg, res_valid_next;
    out_item_t  res_reg, res_next;
    logic [3:0] beat_reg, beat_next;
    logic       load;
    logic       final_beat;

    assign load       = !q_status.empty && (!res_valid_reg || !res_stall);
    assign final_beat = (head.op == JOB_SINGLE) || (beat_reg == BITS_PER_BYTE);
    assign pop        = load && final_beat;
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        beat_next      = beat_reg;
        if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
        if (load)
        begin
            res_valid_next = 1'b1;
            res_next       = head.res;
            if (head.op == JOB_WRITE)
            begin
                if (final_beat)
                begin
                    beat_next     = '0;
                    res_next.kind = 1'b1;
                    res_next.last = 1'b1;
                end
                else
                begin
                    beat_next        = beat_reg + 4'd1;
                    res_next.kind    = 1'b0;
                    res_next.last    = 1'b0;
                    res_next.tx_byte = head.wdata[beat_reg[2:0]] ? SLOT_ONE : SLOT_ZERO;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            beat_reg      <= '0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            beat_reg      <= beat_next;
        end
    end

    `OWMU_ASSERT_ALWAYS(a_beat_range, clk, rst_n, beat_reg <= BITS_PER_BYTE, "slot count out of range")
    `OWMU_ASSERT_IMPLIES(a_beat_write, clk, rst_n, beat_reg != '0, !q_status.empty && head.op == JOB_WRITE, "slot count without write job")

endmodule

// File: rtl/one_wire_master_uart_slots_unit.sv
// Top level of the one-wire bus master sequenced over a UART.
//
// The cmd channel takes transactions of func and data: a bus reset, a byte
// write, a byte read, or a UART echo byte received from the line. The res
// channel returns UART slot bytes to transmit and command completions.
// A write yields eight slot bytes, LSB first, and a completion; every other
// accepted item yields one result, except an echo while idle, which yields
// none. A command issued while a reset or read is running completes at once
// with busy_error set. A running Dallas CRC-8 over read bytes is reported
// on every result and cleared by a bus reset command.
// An accepted item is written into the job queue and then loaded into the
// sequencer's result register. Single-result items flow at one per cycle
// while res_stall is low; the nine results of a write set the sustained rate.
// A queue of QUEUE_DEPTH jobs separates the front end from the sequencer,
// so cmd_stall rises only when that queue is full, for example while
// res_stall is held. Reset returns the bus state to idle, clears the CRC
// and empties the queue.
module one_wire_master_uart_slots_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  owmu_pkg::in_item_t  cmd,
    output logic                res_valid,
    input  logic                res_stall,
    output owmu_pkg::out_item_t res
);
    import owmu_pkg::*;

    queue_status_t q_status;
    logic          push;
    logic          pop;
    job_t          push_job;
    job_t          head;

    owmu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .q_status  (q_status),
        .push      (push),
        .push_job  (push_job)
    );

    owmu_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    owmu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_status  (q_status),
        .head      (head),
        .pop       (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule
